// ===== rtl/stst_pkg.sv =====
package stst_pkg;

  // Stream field widths
  localparam int REQ_W      = 2;
  localparam int IN_SLOT_W  = 32;
  localparam int IN_SLOTS   = 4;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = IN_SLOTS * IN_SLOT_W;
  localparam int OUT_DATA_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam int TLEN_W     = 3;
  localparam logic [REG_IDX_W-1:0] REG_TUPLE_LEN  = 1'b0;
  localparam logic [TLEN_W-1:0]    TUPLE_LEN_RST  = 3'd2;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_PFX  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  // Per-cell update controls
  typedef struct packed {
    logic load_key;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// ===== rtl/sorted_tuple_set_table_top.sv =====
// Sorted tuple set table. Holds up to MAX_ENTRIES distinct tuples of MAX_SLOTS signed slots in
// descending lexicographic order, one tuple per cell of a row of cells; only the first tuple_len
// slots (clamped to 1..MAX_SLOTS) are compared. Each input transaction (tuser = request kind:
// insert, delete, query, clear) yields exactly one result transaction with found, status and the
// element count. A request passes from acceptance to result through the accept state, a compare
// state in which every cell compares its tuple with the key, a state for the registered prefix-OR
// that locates the match and insert point, and an update state in which the cells shift and the
// result is registered. The next request is taken the cycle after the result is registered; the
// update state waits while a previous result is still held at the output. No clearing pass: the
// table is empty right after reset. Write tuple_len only while the table is idle.
module sorted_tuple_set_table_top #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_SLOTS   = 4,
  parameter int SLOT_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [stst_pkg::IN_DATA_W-1:0]    in_tdata,   // slot_a, slot_b, slot_c, slot_d
  input  logic [stst_pkg::REQ_W-1:0]        in_tuser,   // req_type
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stst_pkg::OUT_DATA_W-1:0]   out_tdata,  // found, status[1:0], count[6:0], zeros
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [stst_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [stst_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [stst_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef logic [MAX_SLOTS-1:0][SLOT_WIDTH-1:0] tuple_t;

  stst_pkg::state_t  state_r, state_nxt;
  stst_pkg::req_t    req_r;
  tuple_t            key_r, key_in;
  logic [CW-1:0]     count_r, count_nxt;
  logic [stst_pkg::TLEN_W-1:0] tuple_len_r;
  logic [MAX_SLOTS-1:0] slot_on;

  logic              out_tvalid_r;
  logic [stst_pkg::OUT_DATA_W-1:0] out_data_r;

  tuple_t            entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] eq_v, lt_v, pe, pl, pl_prev;
  stst_pkg::cell_ctl_t ctl [MAX_ENTRIES];

  logic              in_acc;
  logic              commit;
  logic              found;
  logic              do_ins, do_del;
  logic              res_found;
  stst_pkg::status_t res_status;
  logic [stst_pkg::REG_IDX_W-1:0] cfg_idx;
  logic              cfg_we;

  // Slot conversion from the stream width to the stored width
  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_key
    if (k < stst_pkg::IN_SLOTS) begin : g_in
      assign key_in[k] =
        SLOT_WIDTH'($signed(in_tdata[k*stst_pkg::IN_SLOT_W +: stst_pkg::IN_SLOT_W]));
    end else begin : g_zero
      assign key_in[k] = '0;
    end
  end

  // Compared slots: slot 0 always, others below tuple_len
  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      slot_on[k] = (k == 0) || (tuple_len_r > stst_pkg::TLEN_W'(k));
    end
  end

  assign in_tready = (state_r == stst_pkg::S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= key_in;
      req_r <= stst_pkg::req_t'(in_tuser);
    end
  end

  // Row of cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    tuple_t left_e, right_e;
    if (i == 0) begin : g_head
      assign left_e = key_r;
    end else begin : g_mid_l
      assign left_e = entries[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_mid_r
      assign right_e = entries[i+1];
    end

    stst_cell #(
      .MAX_SLOTS  (MAX_SLOTS),
      .SLOT_WIDTH (SLOT_WIDTH)
    ) u_cell (
      .clk         (clk),
      .key         (key_r),
      .slot_on     (slot_on),
      .occupied    (count_r > CW'(i)),
      .left_entry  (left_e),
      .right_entry (right_e),
      .ctl         (ctl[i]),
      .entry       (entries[i]),
      .eq          (eq_v[i]),
      .lt          (lt_v[i])
    );
  end

  // Match and insert-point prefixes
  stst_prefix #(.N(MAX_ENTRIES)) u_pfx_eq (.clk(clk), .vec(eq_v), .pfx(pe));
  stst_prefix #(.N(MAX_ENTRIES)) u_pfx_lt (.clk(clk), .vec(lt_v), .pfx(pl));

  assign pl_prev = pl << 1;
  assign found   = pe[MAX_ENTRIES-1];
  assign commit  = (state_r == stst_pkg::S_UPD) & (~out_tvalid_r | out_tready);

  // Result and count decision
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    res_found  = found;
    res_status = stst_pkg::ST_DONE;
    count_nxt  = count_r;
    case (req_r)
      stst_pkg::REQ_INSERT: begin
        if (found) begin
          res_status = stst_pkg::ST_DUP;
        end else if (count_r == CW'(MAX_ENTRIES)) begin
          res_status = stst_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      stst_pkg::REQ_DELETE: begin
        if (!found) begin
          res_status = stst_pkg::ST_NOT_FOUND;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      stst_pkg::REQ_QUERY: begin
        res_status = found ? stst_pkg::ST_DONE : stst_pkg::ST_NOT_FOUND;
      end
      stst_pkg::REQ_CLEAR: begin
        res_found = 1'b0;
        count_nxt = '0;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // Cell controls: insert opens a gap at the first smaller cell, delete closes the match
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctl[i].load_key   = commit & do_ins & pl[i] & ~pl_prev[i];
      ctl[i].take_left  = commit & do_ins & pl_prev[i];
      ctl[i].take_right = commit & do_del & pe[i];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stst_pkg::S_IDLE: if (in_acc) state_nxt = stst_pkg::S_CMP;
      stst_pkg::S_CMP:  state_nxt = stst_pkg::S_PFX;
      stst_pkg::S_PFX:  state_nxt = stst_pkg::S_UPD;
      stst_pkg::S_UPD:  if (commit) state_nxt = stst_pkg::S_IDLE;
      default:          state_nxt = stst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stst_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) count_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {(stst_pkg::OUT_DATA_W - stst_pkg::COUNT_W - stst_pkg::STATUS_W - 1)'(0),
                     stst_pkg::COUNT_W'(count_nxt), res_status, res_found};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[stst_pkg::CFG_ADDR_W-1:2];
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuple_len_r <= stst_pkg::TUPLE_LEN_RST;
    end else if (cfg_we && (cfg_idx == stst_pkg::REG_TUPLE_LEN)) begin
      tuple_len_r <= cfg_pwdata[stst_pkg::TLEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_idx == stst_pkg::REG_TUPLE_LEN) ?
                      {(stst_pkg::CFG_DATA_W - stst_pkg::TLEN_W)'(0), tuple_len_r} : '0;

endmodule

// ===== rtl/stst_cell.sv =====
module stst_cell #(
  parameter int MAX_SLOTS  = 4,
  parameter int SLOT_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic [MAX_SLOTS-1:0][SLOT_WIDTH-1:0]  key,
  input  logic [MAX_SLOTS-1:0]                  slot_on,
  input  logic                                  occupied,
  input  logic [MAX_SLOTS-1:0][SLOT_WIDTH-1:0]  left_entry,
  input  logic [MAX_SLOTS-1:0][SLOT_WIDTH-1:0]  right_entry,
  input  stst_pkg::cell_ctl_t                   ctl,
  output logic [MAX_SLOTS-1:0][SLOT_WIDTH-1:0]  entry,
  output logic                                  eq,
  output logic                                  lt
);

  logic [MAX_SLOTS-1:0][SLOT_WIDTH-1:0] entry_r;
  logic eq_r;
  logic lt_r;
  logic diff;
  logic less;

  // Lexicographic compare, most significant slot wins
  always_comb begin
    diff = 1'b0;
    less = 1'b0;
    for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
      if (slot_on[k] && (entry_r[k] != key[k])) begin
        diff = 1'b1;
        less = $signed(entry_r[k]) < $signed(key[k]);
      end
    end
  end

  // Flags: an empty cell counts as smaller so an insert lands at the tail
  always_ff @(posedge clk) begin
    eq_r <= occupied & ~diff;
    lt_r <= ~occupied | less;
  end

  // Entry: new key, shift toward tail, or shift toward head
  always_ff @(posedge clk) begin
    if (ctl.load_key) begin
      entry_r <= key;
    end else if (ctl.take_left) begin
      entry_r <= left_entry;
    end else if (ctl.take_right) begin
      entry_r <= right_entry;
    end
  end

  assign entry = entry_r;
  assign eq    = eq_r;
  assign lt    = lt_r;

endmodule

// ===== rtl/stst_prefix.sv =====
module stst_prefix #(
  parameter int N = 64
) (
  input  logic         clk,
  input  logic [N-1:0] vec,
  output logic [N-1:0] pfx
);

  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LV+1];
  logic [N-1:0] pfx_r;

  // Parallel prefix OR, bit i = OR of bits 0..i
  always_comb begin
    lvl[0] = vec;
    for (int k = 0; k < LV; k++) begin
      lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
    end
  end

  always_ff @(posedge clk) begin
    pfx_r <= lvl[LV];
  end

  assign pfx = pfx_r;

endmodule

// ===== rtl/stst_checker.sv =====
module stst_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [stst_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                          res_found;
  logic [stst_pkg::STATUS_W-1:0] res_status;
  logic [stst_pkg::COUNT_W-1:0]  res_count;

  assign res_found  = out_tdata[0];
  assign res_status = out_tdata[stst_pkg::STATUS_W:1];
  assign res_count  = out_tdata[stst_pkg::COUNT_W+stst_pkg::STATUS_W:stst_pkg::STATUS_W+1];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request at a time: busy right after a transaction is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // Duplicate implies the tuple was present
  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_status == stst_pkg::ST_DUP) |-> res_found)
    else $error("duplicate status without found");

  // Full and not-found imply absence
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((res_status == stst_pkg::ST_FULL) ||
                   (res_status == stst_pkg::ST_NOT_FOUND)) |-> !res_found)
    else $error("miss status with found set");

  // Count never exceeds the table size (checked only when the table size fits the 7-bit count field)
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (MAX_ENTRIES > 127) || (res_count <= stst_pkg::COUNT_W'(MAX_ENTRIES)))
    else $error("count above table size");

endmodule

bind sorted_tuple_set_table_top stst_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_stst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
